// ----- src/wdg_pkg.sv -----
`default_nettype none

package wdg_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned FCH_W  = 6;
  localparam int unsigned DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KICK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHECK    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd4;

  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd30000;

  // APB register indexes (word address).
  localparam logic REG_TIMEOUT = 1'b0;

  typedef struct packed {
    logic              fault;
    logic [FCH_W-1:0]  fault_channel;
    logic [DATA_W-1:0] elapsed_ms;
    logic              is_registered;
    logic              feed;
  } res_t;

endpackage

`default_nettype wire

// ----- src/wdg_in_if.sv -----
`default_nettype none

interface wdg_in_if;
  logic                       valid;
  logic                       ready;
  logic [wdg_pkg::MODE_W-1:0] mode;
  logic [wdg_pkg::CHAN_W-1:0] channel;

  modport source (output valid, output mode, output channel, input ready);
  modport sink (input valid, input mode, input channel, output ready);
endinterface

`default_nettype wire

// ----- src/wdg_out_if.sv -----
`default_nettype none

interface wdg_out_if;
  logic                       valid;
  logic                       ready;
  logic                       fault;
  logic [wdg_pkg::FCH_W-1:0]  fault_channel;
  logic [wdg_pkg::DATA_W-1:0] elapsed_ms;
  logic                       is_registered;
  logic                       feed;

  modport source (
    output valid, output fault, output fault_channel, output elapsed_ms,
    output is_registered, output feed, input ready
  );
  modport sink (
    input valid, input fault, input fault_channel, input elapsed_ms,
    input is_registered, input feed, output ready
  );
endinterface

`default_nettype wire

// ----- src/wdg_ram.sv -----
`default_nettype none

module wdg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/wdg_seq.sv -----
`default_nettype none

module wdg_seq #(
  parameter int unsigned NUM_CHANNELS = 8,
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [wdg_pkg::MODE_W-1:0] in_mode_i,
  input  wire logic [wdg_pkg::CHAN_W-1:0] in_channel_i,
  input  wire logic [wdg_pkg::DATA_W-1:0] timeout_i,
  output      wdg_pkg::res_t              res_o,
  output      logic                       res_valid_o,
  input  wire logic                       res_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CHANNELS - 1);

  logic [1:0]                  state_q, state_d;
  logic [wdg_pkg::DATA_W-1:0]  time_q, time_d;
  logic [NUM_CHANNELS-1:0]     active_q, active_d;
  logic [CW-1:0]               idx_q, idx_d;
  wdg_pkg::res_t               res_q, res_d;

  logic                        ram_we;
  logic                        ram_re;
  logic [CW-1:0]               ram_raddr;
  logic [wdg_pkg::DATA_W-1:0]  ram_rdata;
  logic [wdg_pkg::DATA_W-1:0]  elapsed;
  logic                        ch_ok;
  logic [CW-1:0]               ch_idx;

  // Last-kick timestamps. Entries are only used once their channel is
  // registered, and registering writes the entry, so no clearing is needed.
  wdg_ram #(
    .WIDTH (wdg_pkg::DATA_W),
    .DEPTH (NUM_CHANNELS)
  ) u_kick_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_idx),
    .wdata_i (time_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ch_ok      = in_channel_i < wdg_pkg::CHAN_W'(NUM_CHANNELS);
  assign ch_idx     = in_channel_i[CW-1:0];
  assign elapsed    = time_q - ram_rdata;
  assign in_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o      = res_q;

  always_comb begin
    state_d   = state_q;
    time_d    = time_q;
    active_d  = active_q;
    idx_d     = idx_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = ST_DONE;
          unique case (in_mode_i)
            wdg_pkg::MODE_TICK: begin
              time_d = time_q + 1'b1;
            end
            wdg_pkg::MODE_REGISTER: begin
              if (ch_ok) begin
                ram_we           = 1'b1;
                active_d[ch_idx] = 1'b1;
              end
            end
            wdg_pkg::MODE_KICK: begin
              ram_we = ch_ok && active_q[ch_idx];
            end
            wdg_pkg::MODE_CHECK: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = ST_SCAN;
            end
            wdg_pkg::MODE_QUERY: begin
              if (ch_ok && active_q[ch_idx]) begin
                ram_re    = 1'b1;
                ram_raddr = ch_idx;
                state_d   = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_d.elapsed_ms    = elapsed;
        res_d.is_registered = 1'b1;
        state_d             = ST_DONE;
      end
      ST_SCAN: begin
        // The timestamp of channel idx_q is on the read port; the next
        // channel's read is issued in the same cycle.
        if (active_q[idx_q] && (elapsed > timeout_i)) begin
          res_d.fault         = 1'b1;
          res_d.fault_channel = wdg_pkg::FCH_W'(idx_q);
          res_d.elapsed_ms    = elapsed;
          state_d             = ST_DONE;
        end else if (idx_q == LAST_IDX) begin
          res_d.feed = 1'b1;
          state_d    = ST_DONE;
        end else begin
          idx_d     = idx_q + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      time_q   <= '0;
      active_q <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      time_q   <= time_d;
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

// ----- src/multi_channel_software_watchdog.sv -----
// Multi-channel software watchdog. Tick items advance a 32-bit millisecond
// counter; register, kick, check and query items act on up to NUM_CHANNELS
// channels whose last-kick timestamps live in a single-port-read RAM, with
// the registered flags in flip-flops. Every input item yields exactly one
// result beat. Tick, register, kick, unused modes and queries of unregistered
// or out-of-range channels go from idle straight to the result state, a
// query of a registered channel passes through a read state first, and a
// check scans the channels, reading one timestamp per cycle from the RAM
// and stopping at the first expired channel. A finished result waits in an
// output register, so the next item is taken while it is still unread.
// timeout_ms sits at APB byte address 0 and resets to 30000; it should be
// written only while the block is idle.
`default_nettype none

module multi_channel_software_watchdog #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  wdg_in_if.sink                          item_i,
  wdg_out_if.source                       result_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [wdg_pkg::DATA_W-1:0] pwdata,
  output      logic [wdg_pkg::DATA_W-1:0] prdata,
  output      logic                       pready
);

  logic [wdg_pkg::DATA_W-1:0] timeout_q, timeout_d;
  wdg_pkg::res_t              res;
  logic                       res_valid;
  logic                       res_ready;
  wdg_pkg::res_t              out_q;
  logic                       out_valid_q, out_valid_d;

  assign pready = 1'b1;

  always_comb begin
    timeout_d = timeout_q;
    if (psel && penable && pwrite && (paddr[2] == wdg_pkg::REG_TIMEOUT)) begin
      timeout_d = pwdata;
    end
  end

  assign prdata = (paddr[2] == wdg_pkg::REG_TIMEOUT) ? timeout_q : '0;

  wdg_seq #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_ready_o   (item_i.ready),
    .in_mode_i    (item_i.mode),
    .in_channel_i (item_i.channel),
    .timeout_i    (timeout_q),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready)
  );

  // Output register: a new result loads when the slot is empty or its beat
  // is being taken in the same cycle.
  assign res_ready = !out_valid_q || result_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= wdg_pkg::TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      timeout_q   <= timeout_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.fault         = out_q.fault;
  assign result_o.fault_channel = out_q.fault_channel;
  assign result_o.elapsed_ms    = out_q.elapsed_ms;
  assign result_o.is_registered = out_q.is_registered;
  assign result_o.feed          = out_q.feed;

endmodule

`default_nettype wire
